// File: design/heun2d_pkg.sv
// Shared types, constants and codes for the 2D rigid-body Heun integrator.
package heun2d_pkg;

  // Sizes of the body table and of the fixed-point fields.
  localparam int MAX_BODIES = 64;
  localparam int ADDR_W     = $clog2(MAX_BODIES);
  localparam int BODY_W     = 6;
  localparam int VAL_W      = 32;
  localparam int DT_W       = 16;
  localparam int SUM_W      = VAL_W + 1;
  localparam int PROD_W     = SUM_W + DT_W + 1;
  localparam int INC_W      = VAL_W + 2;
  localparam int SAT_W      = VAL_W + 3;
  localparam int FRAC_SH    = 16;
  localparam logic [DT_W-1:0] DT_RESET = 16'd1092;

  // Datapath lanes, one per updated quantity.
  localparam int LANES   = 6;
  localparam int LN_ANG  = 0;
  localparam int LN_AVEL = 1;
  localparam int LN_PX   = 2;
  localparam int LN_PY   = 3;
  localparam int LN_VX   = 4;
  localparam int LN_VY   = 5;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BODY  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STG_UNDEF    = 2'd0,
    STG_PREDICT  = 2'd1,
    STG_CORRECT  = 2'd2,
    STG_COMPLETE = 2'd3
  } stage_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [BODY_W-1:0]       body;
    logic signed [VAL_W-1:0] angle;
    logic signed [VAL_W-1:0] angular_velocity;
    logic signed [VAL_W-1:0] angular_accel;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic signed [VAL_W-1:0] accel_x;
    logic signed [VAL_W-1:0] accel_y;
  } item_t;

  typedef struct packed {
    logic                    out_valid;
    logic [BODY_W-1:0]       out_body;
    logic signed [VAL_W-1:0] new_angle;
    logic signed [VAL_W-1:0] new_angular_velocity;
    logic signed [VAL_W-1:0] new_pos_x;
    logic signed [VAL_W-1:0] new_pos_y;
    logic signed [VAL_W-1:0] new_vel_x;
    logic signed [VAL_W-1:0] new_vel_y;
    logic                    step_done;
    logic [1:0]              stage_now;
  } result_t;

  // One entry of the per-body store.
  typedef struct packed {
    logic signed [VAL_W-1:0] init_angle;
    logic signed [VAL_W-1:0] init_angular_velocity;
    logic signed [VAL_W-1:0] init_angular_accel;
    logic signed [VAL_W-1:0] init_pos_x;
    logic signed [VAL_W-1:0] init_pos_y;
    logic signed [VAL_W-1:0] init_vel_x;
    logic signed [VAL_W-1:0] init_vel_y;
    logic signed [VAL_W-1:0] init_accel_x;
    logic signed [VAL_W-1:0] init_accel_y;
    logic signed [VAL_W-1:0] pred_angular_velocity;
    logic signed [VAL_W-1:0] pred_vel_x;
    logic signed [VAL_W-1:0] pred_vel_y;
  } store_t;

  localparam int STORE_W = $bits(store_t);

  // Decoded control of one transaction, carried down the pipeline.
  typedef struct packed {
    logic       live;
    logic       predict;
    logic       done;
    logic [1:0] stage_now;
  } ctl_t;

endpackage

// File: design/heun_integrator_2d_bodies.sv
// Top level of the 2D rigid-body Heun integrator with its per-body store.
//
// The block takes one transaction per clock when the output side is not
// stalled and no corrector transaction waits, and returns one result per
// transaction, in order, through s1, s2, s3 and the result register.
// Predictor-pass body transactions write their state and the predicted
// velocities into a 64-entry body store through its single write port at the
// end of the pipeline; corrector-pass body transactions read it on acceptance.
// A corrector body transaction therefore waits until predictor writes
// still in the pipeline have landed, which happens once per pass right after
// the close. The store is not cleared after reset: the user must ensure that
// each entry is read only after its predictor pass; the block does not check.
// The time step register is written through time_step_we and time_step and
// applies to every later transaction.
module heun_integrator_2d_bodies (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  heun2d_pkg::item_t                 item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output heun2d_pkg::result_t               result,
  input  logic                              time_step_we,
  input  logic [heun2d_pkg::DT_W-1:0]       time_step
);

  logic [heun2d_pkg::DT_W-1:0] dt;

  heun2d_pkg::ctl_t  in_ctl;
  logic              accept;
  logic              hazard;

  logic              s1v, s2v, s3v;
  heun2d_pkg::ctl_t  s1c, s2c, s3c;
  heun2d_pkg::item_t s1i, s2i, s3i;
  logic              s1_free, s2_free, s3_free, out_free;

  logic [heun2d_pkg::STORE_W-1:0] rd_raw;
  heun2d_pkg::store_t             rd;
  heun2d_pkg::store_t             wr;
  logic                           wr_en;

  logic signed [heun2d_pkg::VAL_W-1:0] lane_base [heun2d_pkg::LANES];
  logic signed [heun2d_pkg::SUM_W-1:0] lane_rate [heun2d_pkg::LANES];
  logic signed [heun2d_pkg::VAL_W-1:0] lane_out  [heun2d_pkg::LANES];

  heun2d_pkg::result_t result_next;

  // Time step register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= heun2d_pkg::DT_RESET;
    end else if (time_step_we) begin
      dt <= time_step;
    end
  end

  heun2d_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (item.cmd),
    .body   (item.body),
    .ctl    (in_ctl)
  );

  // Pipeline flow control; a corrector read waits for pending predictor writes.
  always_comb begin
    out_free   = !result_valid || result_ready;
    s3_free    = !s3v || out_free;
    s2_free    = !s2v || s3_free;
    s1_free    = !s1v || s2_free;
    hazard     = in_ctl.live && !in_ctl.predict &&
                 ((s1v && s1c.live && s1c.predict) ||
                  (s2v && s2c.live && s2c.predict) ||
                  (s3v && s3c.live && s3c.predict));
    item_ready = s1_free && !hazard;
    accept     = item_valid && item_ready;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v          <= 1'b0;
      s2v          <= 1'b0;
      s3v          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_free) s1v <= accept;
      if (s2_free) s2v <= s1v;
      if (s3_free) s3v <= s2v;
      if (out_free) result_valid <= s3v;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1c <= in_ctl;
      s1i <= item;
    end
    if (s1v && s2_free) begin
      s2c <= s1c;
      s2i <= s1i;
    end
    if (s2v && s3_free) begin
      s3c <= s2c;
      s3i <= s2i;
    end
    if (s3v && out_free) begin
      result <= result_next;
    end
  end

  // Body store: read on acceptance, written when a predictor result leaves.
  heun2d_ram #(
    .WIDTH (heun2d_pkg::STORE_W),
    .DEPTH (heun2d_pkg::MAX_BODIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (heun2d_pkg::ADDR_W'(s3i.body)),
    .wr_data (wr),
    .rd_en   (accept),
    .rd_addr (heun2d_pkg::ADDR_W'(item.body)),
    .rd_data (rd_raw)
  );

  assign rd = heun2d_pkg::store_t'(rd_raw);

  // Lane operands: Euler uses the item itself, the corrector the stored state and the item's accelerations.
  always_comb begin
    if (s1c.predict) begin
      lane_base[heun2d_pkg::LN_ANG]  = s1i.angle;
      lane_base[heun2d_pkg::LN_AVEL] = s1i.angular_velocity;
      lane_base[heun2d_pkg::LN_PX]   = s1i.pos_x;
      lane_base[heun2d_pkg::LN_PY]   = s1i.pos_y;
      lane_base[heun2d_pkg::LN_VX]   = s1i.vel_x;
      lane_base[heun2d_pkg::LN_VY]   = s1i.vel_y;
      lane_rate[heun2d_pkg::LN_ANG]  = heun2d_pkg::SUM_W'(s1i.angular_velocity);
      lane_rate[heun2d_pkg::LN_AVEL] = heun2d_pkg::SUM_W'(s1i.angular_accel);
      lane_rate[heun2d_pkg::LN_PX]   = heun2d_pkg::SUM_W'(s1i.vel_x);
      lane_rate[heun2d_pkg::LN_PY]   = heun2d_pkg::SUM_W'(s1i.vel_y);
      lane_rate[heun2d_pkg::LN_VX]   = heun2d_pkg::SUM_W'(s1i.accel_x);
      lane_rate[heun2d_pkg::LN_VY]   = heun2d_pkg::SUM_W'(s1i.accel_y);
    end else begin
      lane_base[heun2d_pkg::LN_ANG]  = rd.init_angle;
      lane_base[heun2d_pkg::LN_AVEL] = rd.init_angular_velocity;
      lane_base[heun2d_pkg::LN_PX]   = rd.init_pos_x;
      lane_base[heun2d_pkg::LN_PY]   = rd.init_pos_y;
      lane_base[heun2d_pkg::LN_VX]   = rd.init_vel_x;
      lane_base[heun2d_pkg::LN_VY]   = rd.init_vel_y;
      lane_rate[heun2d_pkg::LN_ANG]  = heun2d_pkg::SUM_W'(rd.init_angular_velocity) +
                                       heun2d_pkg::SUM_W'(rd.pred_angular_velocity);
      lane_rate[heun2d_pkg::LN_AVEL] = heun2d_pkg::SUM_W'(rd.init_angular_accel) +
                                       heun2d_pkg::SUM_W'(s1i.angular_accel);
      lane_rate[heun2d_pkg::LN_PX]   = heun2d_pkg::SUM_W'(rd.init_vel_x) +
                                       heun2d_pkg::SUM_W'(rd.pred_vel_x);
      lane_rate[heun2d_pkg::LN_PY]   = heun2d_pkg::SUM_W'(rd.init_vel_y) +
                                       heun2d_pkg::SUM_W'(rd.pred_vel_y);
      lane_rate[heun2d_pkg::LN_VX]   = heun2d_pkg::SUM_W'(rd.init_accel_x) +
                                       heun2d_pkg::SUM_W'(s1i.accel_x);
      lane_rate[heun2d_pkg::LN_VY]   = heun2d_pkg::SUM_W'(rd.init_accel_y) +
                                       heun2d_pkg::SUM_W'(s1i.accel_y);
    end
  end

  // Six parallel update lanes.
  for (genvar k = 0; k < heun2d_pkg::LANES; k++) begin : g_lane
    heun2d_lane u_lane (
      .clk       (clk),
      .load2     (s1v && s2_free),
      .load3     (s2v && s3_free),
      .time_step (dt),
      .base      (lane_base[k]),
      .rate      (lane_rate[k]),
      .halve     (!s1c.predict),
      .value     (lane_out[k])
    );
  end

  // Store entry written by a predictor transaction.
  always_comb begin
    wr_en                    = s3v && out_free && s3c.live && s3c.predict;
    wr.init_angle            = s3i.angle;
    wr.init_angular_velocity = s3i.angular_velocity;
    wr.init_angular_accel    = s3i.angular_accel;
    wr.init_pos_x            = s3i.pos_x;
    wr.init_pos_y            = s3i.pos_y;
    wr.init_vel_x            = s3i.vel_x;
    wr.init_vel_y            = s3i.vel_y;
    wr.init_accel_x          = s3i.accel_x;
    wr.init_accel_y          = s3i.accel_y;
    wr.pred_angular_velocity = lane_out[heun2d_pkg::LN_AVEL];
    wr.pred_vel_x            = lane_out[heun2d_pkg::LN_VX];
    wr.pred_vel_y            = lane_out[heun2d_pkg::LN_VY];
  end

  // Result assembly; fields are zero when no body state is carried.
  always_comb begin
    result_next.out_valid            = s3c.live;
    result_next.out_body             = s3c.live ? s3i.body : '0;
    result_next.new_angle            = s3c.live ? lane_out[heun2d_pkg::LN_ANG]  : '0;
    result_next.new_angular_velocity = s3c.live ? lane_out[heun2d_pkg::LN_AVEL] : '0;
    result_next.new_pos_x            = s3c.live ? lane_out[heun2d_pkg::LN_PX]   : '0;
    result_next.new_pos_y            = s3c.live ? lane_out[heun2d_pkg::LN_PY]   : '0;
    result_next.new_vel_x            = s3c.live ? lane_out[heun2d_pkg::LN_VX]   : '0;
    result_next.new_vel_y            = s3c.live ? lane_out[heun2d_pkg::LN_VY]   : '0;
    result_next.step_done            = s3c.done;
    result_next.stage_now            = s3c.stage_now;
  end

endmodule

// File: design/heun2d_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module heun2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/heun2d_ctrl.sv
// Stage sequencer and per-transaction command decode.
module heun2d_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [1:0]                     cmd,
  input  logic [heun2d_pkg::BODY_W-1:0]  body,
  output heun2d_pkg::ctl_t               ctl
);

  heun2d_pkg::stage_t stage;
  heun2d_pkg::stage_t stage_next;

  // Next stage for the offered command.
  always_comb begin
    stage_next = stage;
    case (heun2d_pkg::cmd_t'(cmd))
      heun2d_pkg::CMD_START: stage_next = heun2d_pkg::STG_PREDICT;
      heun2d_pkg::CMD_END:   stage_next = heun2d_pkg::STG_UNDEF;
      heun2d_pkg::CMD_CLOSE: begin
        case (stage)
          heun2d_pkg::STG_PREDICT:  stage_next = heun2d_pkg::STG_CORRECT;
          heun2d_pkg::STG_CORRECT:  stage_next = heun2d_pkg::STG_COMPLETE;
          heun2d_pkg::STG_COMPLETE: stage_next = heun2d_pkg::STG_PREDICT;
          default:                  stage_next = heun2d_pkg::STG_UNDEF;
        endcase
      end
      default: stage_next = stage;
    endcase
  end

  // Decode of the offered transaction against the current stage.
  always_comb begin
    ctl.live      = (heun2d_pkg::cmd_t'(cmd) == heun2d_pkg::CMD_BODY) &&
                    (int'(body) < heun2d_pkg::MAX_BODIES) &&
                    ((stage == heun2d_pkg::STG_PREDICT) ||
                     (stage == heun2d_pkg::STG_CORRECT));
    ctl.predict   = (stage == heun2d_pkg::STG_PREDICT);
    ctl.done      = (heun2d_pkg::cmd_t'(cmd) == heun2d_pkg::CMD_CLOSE) &&
                    (stage == heun2d_pkg::STG_CORRECT);
    ctl.stage_now = stage_next;
  end

  // Stage register advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= heun2d_pkg::STG_UNDEF;
    end else if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

// File: design/heun2d_lane.sv
// One update lane: scaled multiply by the time step, rounding and saturating add.
module heun2d_lane (
  input  logic                                  clk,
  input  logic                                  load2,
  input  logic                                  load3,
  input  logic [heun2d_pkg::DT_W-1:0]           time_step,
  input  logic signed [heun2d_pkg::VAL_W-1:0]   base,
  input  logic signed [heun2d_pkg::SUM_W-1:0]   rate,
  input  logic                                  halve,
  output logic signed [heun2d_pkg::VAL_W-1:0]   value
);

  logic signed [heun2d_pkg::VAL_W-1:0]  base2;
  logic signed [heun2d_pkg::SUM_W-1:0]  rate2;
  logic                                 halve2;
  logic signed [heun2d_pkg::VAL_W-1:0]  base3;
  logic signed [heun2d_pkg::PROD_W-1:0] prod3;
  logic                                 halve3;

  logic signed [heun2d_pkg::DT_W:0]       dt_s;
  logic signed [heun2d_pkg::PROD_W-1:0]   prod_next;
  logic [heun2d_pkg::PROD_W-1:0]          half;
  logic signed [heun2d_pkg::PROD_W-1:0]   rnd;
  logic signed [heun2d_pkg::PROD_W-1:0]   shf;
  logic signed [heun2d_pkg::SAT_W-1:0]    sum;
  logic [heun2d_pkg::SAT_W-heun2d_pkg::VAL_W:0] upper;

  // Operand register.
  always_ff @(posedge clk) begin
    if (load2) begin
      base2  <= base;
      rate2  <= rate;
      halve2 <= halve;
    end
  end

  // Exact product of the rate and the unsigned time step.
  always_comb begin
    dt_s      = $signed({1'b0, time_step});
    prod_next = heun2d_pkg::PROD_W'(rate2) * heun2d_pkg::PROD_W'(dt_s);
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      base3  <= base2;
      prod3  <= prod_next;
      halve3 <= halve2;
    end
  end

  // Round half up, shift back to Q16.16 (halving in corrector mode) and add with saturation.
  always_comb begin
    half  = halve3 ? (heun2d_pkg::PROD_W'(1) << heun2d_pkg::FRAC_SH)
                   : (heun2d_pkg::PROD_W'(1) << (heun2d_pkg::FRAC_SH - 1));
    rnd   = prod3 + $signed(half);
    shf   = halve3 ? (rnd >>> (heun2d_pkg::FRAC_SH + 1)) : (rnd >>> heun2d_pkg::FRAC_SH);
    sum   = heun2d_pkg::SAT_W'(base3) + heun2d_pkg::SAT_W'($signed(shf[heun2d_pkg::INC_W-1:0]));
    upper = sum[heun2d_pkg::SAT_W-1:heun2d_pkg::VAL_W-1];
    if ((upper == '0) || (upper == '1)) begin
      value = sum[heun2d_pkg::VAL_W-1:0];
    end else if (sum[heun2d_pkg::SAT_W-1]) begin
      value = {1'b1, {(heun2d_pkg::VAL_W-1){1'b0}}};
    end else begin
      value = {1'b0, {(heun2d_pkg::VAL_W-1){1'b1}}};
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the 2D rigid-body Heun integrator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import heun2d_pkg::*;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // Saved state of one body between the predictor and the corrector pass.
  typedef struct {
    int ang, avel, aacc, px, py, vx, vy, ax, ay;
    int p_avel, p_vx, p_vy;
  } body_rec_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  logic    time_step_we;
  logic [DT_W-1:0] time_step;

  // Mirror of the block state, advanced as each transaction is accepted.
  stage_t    cur_stage;
  int        dt_q;
  body_rec_t body_tab [MAX_BODIES];
  bit        loaded [MAX_BODIES];
  int        loaded_list [$];

  result_t expected_results [$];
  result_t want_r;
  int      idle_pct;
  int      err_count;
  int      n_sent;
  int      n_checked;
  int      n_updates;
  int      n_steps;
  int      n_dt_writes;

  heun_integrator_2d_bodies dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .time_step_we (time_step_we),
    .time_step    (time_step)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Fixed-point helpers: round half up to the floor, then saturate to 32 bits.
  function automatic longint round_shift(longint p, int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic int clamp32(longint s);
    if (s > I32_MAX) return int'(I32_MAX);
    if (s < I32_MIN) return int'(I32_MIN);
    return int'(s);
  endfunction

  function automatic int euler_term(int base, int rate);
    return clamp32(longint'(base) + round_shift(longint'(rate) * longint'(dt_q), 16));
  endfunction

  function automatic int heun_term(int base, int r0, int r1);
    longint sum;
    sum = longint'(r0) + longint'(r1);
    return clamp32(longint'(base) + round_shift(sum * longint'(dt_q), 17));
  endfunction

  // Expected result of one accepted transaction; updates the mirrored state.
  function automatic result_t heun_predict(item_t it);
    result_t   r;
    body_rec_t e;
    int        b;
    r = '0;
    b = it.body;
    case (cmd_t'(it.cmd))
      CMD_START: cur_stage = STG_PREDICT;
      CMD_END:   cur_stage = STG_UNDEF;
      CMD_CLOSE: begin
        case (cur_stage)
          STG_PREDICT: cur_stage = STG_CORRECT;
          STG_CORRECT: begin
            cur_stage = STG_COMPLETE;
            r.step_done = 1'b1;
          end
          STG_COMPLETE: cur_stage = STG_PREDICT;
          default: ;
        endcase
      end
      default: begin
        if (b < MAX_BODIES && cur_stage == STG_PREDICT) begin
          r.out_valid = 1'b1;
          r.out_body = it.body;
          e.ang  = it.angle;
          e.avel = it.angular_velocity;
          e.aacc = it.angular_accel;
          e.px   = it.pos_x;
          e.py   = it.pos_y;
          e.vx   = it.vel_x;
          e.vy   = it.vel_y;
          e.ax   = it.accel_x;
          e.ay   = it.accel_y;
          r.new_angle            = euler_term(e.ang, e.avel);
          r.new_angular_velocity = euler_term(e.avel, e.aacc);
          r.new_pos_x            = euler_term(e.px, e.vx);
          r.new_pos_y            = euler_term(e.py, e.vy);
          r.new_vel_x            = euler_term(e.vx, e.ax);
          r.new_vel_y            = euler_term(e.vy, e.ay);
          e.p_avel = r.new_angular_velocity;
          e.p_vx   = r.new_vel_x;
          e.p_vy   = r.new_vel_y;
          body_tab[b] = e;
          if (!loaded[b]) loaded_list.push_back(b);
          loaded[b] = 1'b1;
        end else if (b < MAX_BODIES && cur_stage == STG_CORRECT) begin
          e = body_tab[b];
          r.out_valid = 1'b1;
          r.out_body = it.body;
          r.new_angle            = heun_term(e.ang, e.avel, e.p_avel);
          r.new_angular_velocity = heun_term(e.avel, e.aacc, it.angular_accel);
          r.new_pos_x            = heun_term(e.px, e.vx, e.p_vx);
          r.new_pos_y            = heun_term(e.py, e.vy, e.p_vy);
          r.new_vel_x            = heun_term(e.vx, e.ax, it.accel_x);
          r.new_vel_y            = heun_term(e.vy, e.ay, it.accel_y);
        end
      end
    endcase
    r.stage_now = cur_stage;
    return r;
  endfunction

  // Result checker: each result transaction against the oldest expectation.
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      err_count++;
      if (err_count < 60) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count < 60) $error("result transaction with no expectation pending");
      end else begin
        want_r = expected_results.pop_front();
        n_checked++;
        if (want_r.out_valid) n_updates++;
        if (want_r.step_done) n_steps++;
        check_field("out_valid", want_r.out_valid, result.out_valid);
        check_field("out_body", want_r.out_body, result.out_body);
        check_field("new_angle", want_r.new_angle, result.new_angle);
        check_field("new_angular_velocity", want_r.new_angular_velocity,
                    result.new_angular_velocity);
        check_field("new_pos_x", want_r.new_pos_x, result.new_pos_x);
        check_field("new_pos_y", want_r.new_pos_y, result.new_pos_y);
        check_field("new_vel_x", want_r.new_vel_x, result.new_vel_x);
        check_field("new_vel_y", want_r.new_vel_y, result.new_vel_y);
        check_field("step_done", want_r.step_done, result.step_done);
        check_field("stage_now", want_r.stage_now, result.stage_now);
      end
    end
  end

  // Output side: ready drops in random bursts while idling is enabled.
  initial begin
    int hold;
    hold = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        hold = $urandom_range(1, 8);
      if (hold > 0) begin
        result_ready <= 1'b0;
        hold--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offers one transaction, with an optional gap first, and waits for acceptance.
  task automatic send_item(input item_t it);
    int gap;
    gap = (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_results.push_back(heun_predict(it));
    n_sent++;
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_time_step(input int v);
    wait_drained();
    @(negedge clk);
    time_step_we <= 1'b1;
    time_step <= v[DT_W-1:0];
    @(negedge clk);
    time_step_we <= 1'b0;
    dt_q = v;
    n_dt_writes++;
  endtask

  // Q16.16 values biased toward the extremes and toward small magnitudes.
  function automatic int rand_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t make_item(cmd_t c, int b);
    item_t it;
    it.cmd = c;
    it.body = b[BODY_W-1:0];
    it.angle = rand_val();
    it.angular_velocity = rand_val();
    it.angular_accel = rand_val();
    it.pos_x = rand_val();
    it.pos_y = rand_val();
    it.vel_x = rand_val();
    it.vel_y = rand_val();
    it.accel_x = rand_val();
    it.accel_y = rand_val();
    return it;
  endfunction

  function automatic item_t filled_item(cmd_t c, int b, int v);
    item_t it;
    it = make_item(c, b);
    it.angle = v;
    it.angular_velocity = v;
    it.angular_accel = v;
    it.pos_x = v;
    it.pos_y = v;
    it.vel_x = v;
    it.vel_y = v;
    it.accel_x = v;
    it.accel_y = v;
    return it;
  endfunction

  // Mostly a few low indices so that passes revisit bodies, sometimes any.
  function automatic int pick_index();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_BODIES - 1)
                                       : $urandom_range(0, 7);
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic send_ctl(input cmd_t c);
    send_item(make_item(c, $urandom_range(0, MAX_BODIES - 1)));
  endtask

  task automatic send_body(input int b);
    send_item(make_item(CMD_BODY, b));
  endtask

  // One well-formed step: predictor pass, corrector pass, and stray traffic.
  task automatic run_step(input int n);
    int ids [$];
    int b;
    int k;
    send_ctl(CMD_START);
    repeat (n) begin
      b = pick_index();
      ids.push_back(b);
      send_body(b);
    end
    send_ctl(CMD_CLOSE);
    while (ids.size() != 0) begin
      k = $urandom_range(0, ids.size() - 1);
      b = ids[k];
      ids.delete(k);
      if ($urandom_range(0, 5) != 0) send_body(b);
    end
    if ($urandom_range(0, 3) == 0) send_body(pick_loaded());
    send_ctl(CMD_CLOSE);
    if ($urandom_range(0, 3) == 0) send_body(pick_index());
  endtask

  // Any command; a corrector body only ever names a body that was stored.
  task automatic send_random();
    cmd_t c;
    c = cmd_t'($urandom_range(0, 3));
    if (c == CMD_BODY && cur_stage == STG_CORRECT && loaded_list.size() == 0)
      c = CMD_CLOSE;
    if (c == CMD_BODY && cur_stage == STG_CORRECT)
      send_body(pick_loaded());
    else
      send_item(make_item(c, $urandom_range(0, MAX_BODIES - 1)));
  endtask

  // Stage walk at the reset time step, with extreme and zero bodies.
  task automatic test_directed();
    send_body(5);
    send_ctl(CMD_CLOSE);
    send_ctl(CMD_END);
    send_ctl(CMD_START);
    send_item(filled_item(CMD_BODY, 0, 32'h7fff_ffff));
    send_item(filled_item(CMD_BODY, MAX_BODIES - 1, 32'h8000_0000));
    send_item(filled_item(CMD_BODY, 1, 0));
    send_body(2);
    send_ctl(CMD_START);
    send_ctl(CMD_CLOSE);
    send_item(filled_item(CMD_BODY, 0, 32'h7fff_ffff));
    send_item(filled_item(CMD_BODY, MAX_BODIES - 1, 32'h8000_0000));
    send_item(filled_item(CMD_BODY, 1, 0));
    send_body(2);
    send_ctl(CMD_CLOSE);
    send_body(2);
    send_ctl(CMD_START);
    send_body(2);
    send_ctl(CMD_CLOSE);
    send_ctl(CMD_END);
    send_ctl(CMD_START);
    send_ctl(CMD_CLOSE);
    send_ctl(CMD_START);
    send_ctl(CMD_CLOSE);
    send_ctl(CMD_CLOSE);
    send_ctl(CMD_CLOSE);
  endtask

  // Steps at the edge settings of the time step.
  task automatic test_time_step_extremes();
    set_time_step(16'hffff);
    run_step(4);
    set_time_step(0);
    run_step(4);
    set_time_step(1);
    run_step(3);
    set_time_step(16'h8000);
    run_step(4);
  endtask

  // Phases of random steps and noise, each with its own time step and idling.
  task automatic test_random_steps();
    int base;
    int phase;
    base = n_sent;
    for (phase = 0; phase < 8; phase++) begin
      set_time_step((phase == 0) ? int'(DT_RESET) : $urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 25;
        default: idle_pct = 50;
      endcase
      if (phase == 7) idle_pct = 0;
      while (n_sent < base + (phase + 1) * 72) begin
        if ($urandom_range(0, 6) == 0)
          repeat ($urandom_range(1, 4)) send_random();
        else
          run_step($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    time_step_we = 1'b0;
    time_step = '0;
    cur_stage = STG_UNDEF;
    dt_q = DT_RESET;
    idle_pct = 20;
    err_count = 0;
    n_sent = 0;
    n_checked = 0;
    n_updates = 0;
    n_steps = 0;
    n_dt_writes = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_time_step_extremes();
    test_random_steps();
    wait_drained();

    $display("tb_top: %0d transactions sent, %0d results checked, %0d body updates",
             n_sent, n_checked, n_updates);
    $display("tb_top: %0d completed steps over %0d time step settings",
             n_steps, n_dt_writes + 1);
    if (err_count == 0 && expected_results.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
